### hw/rtl/oqsr_pkg.sv
package oqsr_pkg;

    // Default sizes of the queue
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int HANDLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int TID_BITS  = 16;
    localparam int KIND_BITS = 2;

    // Request kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUT    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,   // keep contents
        CMD_LOAD = 2'd1,   // first empty cell takes the new entry
        CMD_DROP = 2'd2,   // shift toward the head, tail cell empties
        CMD_WRAP = 2'd3    // shift toward the head, tail cell takes the head entry
    } cell_cmd_t;

    // Control bundle handed to the cells
    typedef struct packed {
        cell_cmd_t cmd;
    } cell_ctrl_t;

endpackage

### hw/rtl/oqsr_cell.sv
module oqsr_cell #(
    parameter int HANDLE_BITS = oqsr_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  oqsr_pkg::cell_ctrl_t          ctrl,
    input  logic                          prev_valid,
    input  logic                          nxt_valid,
    input  logic [HANDLE_BITS-1:0]        nxt_task,
    input  logic [oqsr_pkg::TID_BITS-1:0] nxt_tid,
    input  logic [HANDLE_BITS-1:0]        nxt_thr,
    input  logic [HANDLE_BITS-1:0]        head_task,
    input  logic [oqsr_pkg::TID_BITS-1:0] head_tid,
    input  logic [HANDLE_BITS-1:0]        head_thr,
    input  logic [HANDLE_BITS-1:0]        load_task,
    input  logic [oqsr_pkg::TID_BITS-1:0] load_tid,
    input  logic [HANDLE_BITS-1:0]        load_thr,
    output logic                          valid,
    output logic [HANDLE_BITS-1:0]        task_val,
    output logic [oqsr_pkg::TID_BITS-1:0] tid_val,
    output logic [HANDLE_BITS-1:0]        thr_val
);

    logic                          valid_reg, valid_next;
    logic [HANDLE_BITS-1:0]        task_reg, task_next;
    logic [oqsr_pkg::TID_BITS-1:0] tid_reg, tid_next;
    logic [HANDLE_BITS-1:0]        thr_reg, thr_next;

    // Pick the next contents of this cell
    always_comb
    begin
        valid_next = valid_reg;
        task_next  = task_reg;
        tid_next   = tid_reg;
        thr_next   = thr_reg;
        unique case (ctrl.cmd)
            oqsr_pkg::CMD_HOLD:
            begin
            end
            oqsr_pkg::CMD_LOAD:
            begin
                if (!valid_reg && prev_valid)
                begin
                    valid_next = 1'b1;
                    task_next  = load_task;
                    tid_next   = load_tid;
                    thr_next   = load_thr;
                end
            end
            oqsr_pkg::CMD_DROP:
            begin
                if (nxt_valid)
                begin
                    task_next = nxt_task;
                    tid_next  = nxt_tid;
                    thr_next  = nxt_thr;
                end
                else
                begin
                    valid_next = 1'b0;
                end
            end
            oqsr_pkg::CMD_WRAP:
            begin
                if (nxt_valid)
                begin
                    task_next = nxt_task;
                    tid_next  = nxt_tid;
                    thr_next  = nxt_thr;
                end
                else if (valid_reg)
                begin
                    task_next = head_task;
                    tid_next  = head_tid;
                    thr_next  = head_thr;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the entry payload
    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        tid_reg  <= tid_next;
        thr_reg  <= thr_next;
    end

    assign valid    = valid_reg;
    assign task_val = task_reg;
    assign tid_val  = tid_reg;
    assign thr_val  = thr_reg;

endmodule

### hw/rtl/ordered_queue_search_remove.sv
// Channel   | Ports                                              | Timing
// ----------+----------------------------------------------------+-------------------------------
// request   | start, busy, kind, task_handle, thread_id,         | taken when start & !busy
//           | thread_handle                                      |
// result    | done, hit, task_out, thread_out, count, overflow   | valid only in the cycle of done
//
// Put and get answer in the cycle after the request, and a new request may follow at once.
// Find and remove rotate the whole queue once through the head cell, one slot per cycle,
// and the result comes when the rotation ends; on an empty queue it comes in the cycle after.
// Reset clears the cell occupied flags and the count; entry payloads are never cleared.
// The receiver cannot stall: done is a one-cycle strobe and busy only holds off requests.
module ordered_queue_search_remove #(
    parameter int QUEUE_DEPTH = oqsr_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = oqsr_pkg::HANDLE_BITS_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [oqsr_pkg::KIND_BITS-1:0] kind,
    input  logic [HANDLE_BITS-1:0]         task_handle,
    input  logic [oqsr_pkg::TID_BITS-1:0]  thread_id,
    input  logic [HANDLE_BITS-1:0]         thread_handle,
    output logic                           done,
    output logic                           hit,
    output logic [HANDLE_BITS-1:0]         task_out,
    output logic [HANDLE_BITS-1:0]         thread_out,
    output logic [CNT_W-1:0]               count,
    output logic                           overflow
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              steps_reg, steps_next;
    logic                          found_reg, found_next;
    logic [HANDLE_BITS-1:0]        thr_found_reg, thr_found_next;
    oqsr_pkg::kind_t               key_kind_reg, key_kind_next;
    logic [HANDLE_BITS-1:0]        key_task_reg, key_task_next;
    logic [oqsr_pkg::TID_BITS-1:0] key_tid_reg, key_tid_next;

    logic                          done_reg, done_next;
    logic                          hit_reg, hit_next;
    logic [HANDLE_BITS-1:0]        task_out_reg, task_out_next;
    logic [HANDLE_BITS-1:0]        thread_out_reg, thread_out_next;
    logic [CNT_W-1:0]              res_count_reg, res_count_next;
    logic                          ovf_reg, ovf_next;

    oqsr_pkg::cell_ctrl_t          ctrl;
    logic                          match;

    logic                          cell_valid [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0]        cell_task  [QUEUE_DEPTH];
    logic [oqsr_pkg::TID_BITS-1:0] cell_tid   [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0]        cell_thr   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]        valid_vec;

    // Chain of cells, head in cell 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                          prev_v;
        logic                          nxt_v;
        logic [HANDLE_BITS-1:0]        nxt_task;
        logic [oqsr_pkg::TID_BITS-1:0] nxt_tid;
        logic [HANDLE_BITS-1:0]        nxt_thr;

        if (i == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_inner
            assign prev_v = cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nxt_v    = 1'b0;
            assign nxt_task = '0;
            assign nxt_tid  = '0;
            assign nxt_thr  = '0;
        end
        else
        begin : g_link
            assign nxt_v    = cell_valid[i+1];
            assign nxt_task = cell_task[i+1];
            assign nxt_tid  = cell_tid[i+1];
            assign nxt_thr  = cell_thr[i+1];
        end

        oqsr_cell #(
            .HANDLE_BITS(HANDLE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_valid(prev_v),
            .nxt_valid (nxt_v),
            .nxt_task  (nxt_task),
            .nxt_tid   (nxt_tid),
            .nxt_thr   (nxt_thr),
            .head_task (cell_task[0]),
            .head_tid  (cell_tid[0]),
            .head_thr  (cell_thr[0]),
            .load_task (task_handle),
            .load_tid  (thread_id),
            .load_thr  (thread_handle),
            .valid     (cell_valid[i]),
            .task_val  (cell_task[i]),
            .tid_val   (cell_tid[i]),
            .thr_val   (cell_thr[i])
        );

        assign valid_vec[i] = cell_valid[i];
    end

    // Compare the head cell against the search key
    always_comb
    begin
        if (key_kind_reg == oqsr_pkg::KIND_FIND)
            match = !found_reg && (cell_tid[0] == key_tid_reg);
        else
            match = !found_reg && (cell_task[0] == key_task_reg);
    end

    // Sequence requests and drive the chain
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        found_next      = found_reg;
        thr_found_next  = thr_found_reg;
        key_kind_next   = key_kind_reg;
        key_task_next   = key_task_reg;
        key_tid_next    = key_tid_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        task_out_next   = task_out_reg;
        thread_out_next = thread_out_reg;
        res_count_next  = res_count_reg;
        ovf_next        = ovf_reg;
        ctrl.cmd        = oqsr_pkg::CMD_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    hit_next        = 1'b0;
                    task_out_next   = '0;
                    thread_out_next = '0;
                    ovf_next        = 1'b0;
                    key_kind_next   = oqsr_pkg::kind_t'(kind);
                    key_task_next   = task_handle;
                    key_tid_next    = thread_id;
                    found_next      = 1'b0;
                    thr_found_next  = '0;
                    unique case (oqsr_pkg::kind_t'(kind)) inside
                        oqsr_pkg::KIND_PUT:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.cmd   = oqsr_pkg::CMD_LOAD;
                                count_next = count_reg + CNT_W'(1);
                                hit_next   = 1'b1;
                            end
                        end
                        oqsr_pkg::KIND_GET:
                        begin
                            done_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                ctrl.cmd      = oqsr_pkg::CMD_DROP;
                                count_next    = count_reg - CNT_W'(1);
                                hit_next      = 1'b1;
                                task_out_next = cell_task[0];
                            end
                        end
                        oqsr_pkg::KIND_FIND, oqsr_pkg::KIND_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                steps_next = count_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_count_next = count_next;
                end
            end
            ST_SCAN:
            begin
                // Drop the first matching entry on remove, rotate otherwise
                if (match && key_kind_reg == oqsr_pkg::KIND_REMOVE)
                begin
                    ctrl.cmd   = oqsr_pkg::CMD_DROP;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    ctrl.cmd = oqsr_pkg::CMD_WRAP;
                end
                if (match)
                begin
                    found_next     = 1'b1;
                    thr_found_next = cell_thr[0];
                end
                steps_next = steps_reg - CNT_W'(1);
                if (steps_reg == CNT_W'(1))
                begin
                    state_next     = ST_IDLE;
                    done_next      = 1'b1;
                    hit_next       = found_next;
                    res_count_next = count_next;
                    if (key_kind_reg == oqsr_pkg::KIND_FIND)
                        thread_out_next = thr_found_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            steps_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // Hold keys and result payload
    always_ff @(posedge clk)
    begin
        thr_found_reg  <= thr_found_next;
        key_kind_reg   <= key_kind_next;
        key_task_reg   <= key_task_next;
        key_tid_reg    <= key_tid_next;
        hit_reg        <= hit_next;
        task_out_reg   <= task_out_next;
        thread_out_reg <= thread_out_next;
        res_count_reg  <= res_count_next;
        ovf_reg        <= ovf_next;
    end

    assign busy       = (state_reg == ST_SCAN);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign task_out   = task_out_reg;
    assign thread_out = thread_out_reg;
    assign count      = res_count_reg;
    assign overflow   = ovf_reg;

    // The count always tracks the occupied cells
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(valid_vec)) == count_reg)
        else $error("entry count differs from occupied cells");

    // Occupied cells form a contiguous run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("gap in occupied cells");

    // A scan never runs with no steps left
    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> steps_reg != '0)
        else $error("scan with zero steps");

    // A dropped put never reports a hit
    a_ovf_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && ovf_reg |-> !hit_reg)
        else $error("overflow reported together with hit");

    // A scan finishes with the result strobe
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && steps_reg == CNT_W'(1) |=> done_reg)
        else $error("scan ended without result");

endmodule
